FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Delayed form: the consequent must hold after the antecedent.
`define ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/mpes_pkg.sv
// Shared types and constants of the median prefilter and exponential smoother.
package mpes_pkg;

  localparam int WINDOW_LEN  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int ALPHA_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int SLOT_W      = $clog2(WINDOW_LEN);
  localparam int RANK_W      = $clog2(WINDOW_LEN);
  localparam int MED_IDX     = WINDOW_LEN / 2;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(57123);

  typedef logic signed [SAMPLE_BITS-1:0] sample_word_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic        [ALPHA_BITS-1:0]  alpha_t;
  typedef logic        [SLOT_W-1:0]      slot_t;
  typedef sample_word_t                  window_t [WINDOW_LEN];

endpackage

FILE: hdl/mpes_median.sv
// Rank-based median selection over the sample window.
module mpes_median (
  input  mpes_pkg::window_t      window_i,
  output mpes_pkg::sample_word_t median_o
);
  import mpes_pkg::*;

  logic [RANK_W-1:0] rank [WINDOW_LEN];

  // Each element counts the elements that sort ahead of it; equal values
  // are ordered by position so that every rank is taken exactly once.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          if ((window_i[j] < window_i[i]) || ((j < i) && (window_i[j] == window_i[i]))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (rank[i] == RANK_W'(MED_IDX)) begin
        median_o = median_o | window_i[i];
      end
    end
  end

endmodule

FILE: hdl/mpes_smoother.sv
// First-order low-pass update in Q16.16 with rounding and saturation.
module mpes_smoother (
  input  mpes_pkg::alpha_t       alpha_i,
  input  mpes_pkg::acc_t         prev_i,
  input  mpes_pkg::sample_word_t median_i,
  output mpes_pkg::acc_t         next_prev_o,
  output mpes_pkg::sample_word_t filtered_o
);
  import mpes_pkg::*;

  localparam int DIFF_W = ACC_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_BITS + 1;
  localparam int CORR_W = PROD_W - FRAC_BITS;

  logic signed [DIFF_W-1:0]      med_q16;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_rnd;
  logic signed [CORR_W-1:0]      corr;
  logic signed [CORR_W-1:0]      sum;
  logic signed [ACC_W:0]         y_rnd;
  logic signed [SAMPLE_BITS:0]   y_int;

  // alpha*p + (1-alpha)*m equals m + alpha*(p - m), so one multiply suffices.
  assign med_q16  = {median_i[SAMPLE_BITS-1], median_i, {FRAC_BITS{1'b0}}};
  assign diff     = {prev_i[ACC_W-1], prev_i} - med_q16;
  assign prod     = PROD_W'($signed({1'b0, alpha_i})) * PROD_W'(diff);
  assign prod_rnd = prod + PROD_W'(ROUND_HALF);
  assign corr     = prod_rnd[PROD_W-1:FRAC_BITS];
  assign sum      = {med_q16[DIFF_W-1], med_q16} + corr;
  assign next_prev_o = sum[ACC_W-1:0];

  assign y_rnd = {next_prev_o[ACC_W-1], next_prev_o} + (ACC_W+1)'(ROUND_HALF);
  assign y_int = y_rnd[ACC_W:FRAC_BITS];

  always_comb begin
    if (y_int[SAMPLE_BITS] != y_int[SAMPLE_BITS-1]) begin
      filtered_o = y_int[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      filtered_o = y_int[SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: hdl/median_prefilter_exponential_smoother_core.sv
// Top level of the median prefilter and exponential smoother.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_ready_o | sample_in_i
//   out     | output    | out_valid_o/out_ready_i | filtered_out_o, window_median_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | smoothing_alpha_i
//
// Each transaction on the input channel yields exactly one output transaction,
// through the input register and then the output register. One transaction
// is accepted per cycle while the output side is not stalled: the throughput
// is set by the single multiply-add that closes the smoother recurrence.
// Reset clears the input and output valid flags, the primed flag and the write
// slot and loads the default alpha; the first sample after reset then fills the
// window and the filter state with its own value.
// While the output register holds an untaken result, the input register still
// takes one more transaction before in_ready_o drops.
module median_prefilter_exponential_smoother_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mpes_pkg::sample_word_t sample_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mpes_pkg::sample_word_t filtered_out_o,
  output mpes_pkg::sample_word_t window_median_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  mpes_pkg::alpha_t      smoothing_alpha_i
);
  import mpes_pkg::*;

  // Input register stage.
  logic         in_vld_q;
  sample_word_t in_sample_q;

  // Filter state.
  logic         primed_q;
  slot_t        slot_q;
  window_t      window_q;
  acc_t         prev_q;
  alpha_t       alpha_q;

  // Output register stage.
  logic         out_vld_q;
  sample_word_t out_filt_q;
  sample_word_t out_med_q;

  logic         fire;
  window_t      win_eff;
  acc_t         prev_eff;
  slot_t        slot_base;
  slot_t        slot_d;
  sample_word_t median;
  acc_t         prev_d;
  sample_word_t filt;

  // The work stage advances when it holds a sample and the output register
  // is free or being emptied in this cycle.
  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;

  // Before the first sample is taken, the window and the filter state read
  // as copies of that sample, and the write slot starts from zero.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (!primed_q || (slot_q == SLOT_W'(i))) begin
        win_eff[i] = in_sample_q;
      end else begin
        win_eff[i] = window_q[i];
      end
    end
    prev_eff  = primed_q ? prev_q : {in_sample_q, {FRAC_BITS{1'b0}}};
    slot_base = primed_q ? slot_q : '0;
    slot_d    = (slot_base == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_base + SLOT_W'(1);
  end

  mpes_median u_median (
    .window_i (win_eff),
    .median_o (median)
  );

  mpes_smoother u_smoother (
    .alpha_i     (alpha_q),
    .prev_i      (prev_eff),
    .median_i    (median),
    .next_prev_o (prev_d),
    .filtered_o  (filt)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      primed_q  <= 1'b0;
      slot_q    <= '0;
      alpha_q   <= ALPHA_RESET;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        primed_q  <= 1'b1;
        slot_q    <= slot_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        alpha_q <= smoothing_alpha_i;
      end
    end
  end

  // Payload registers; the primed flag and the valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_sample_q <= sample_in_i;
    end
    if (fire) begin
      window_q   <= win_eff;
      prev_q     <= prev_d;
      out_filt_q <= filt;
      out_med_q  <= median;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign filtered_out_o  = out_filt_q;
  assign window_median_o = out_med_q;

endmodule

FILE: hdl/mpes_checker.sv
// Port-level checker for the median prefilter and exponential smoother.
`include "assert_macros.svh"

module mpes_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input mpes_pkg::sample_word_t filtered_out_o,
  input mpes_pkg::sample_word_t window_median_o
);
  import mpes_pkg::*;

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
               $stable(filtered_out_o) && $stable(window_median_o))

  // An empty output register never blocks the input side.
  `ASSERT_IMPLIES(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // An accepted sample is followed by a valid output once the input and output registers are passed.
  `ASSERT_AFTER2(a_result_latency, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

endmodule

bind median_prefilter_exponential_smoother_core mpes_checker u_mpes_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .filtered_out_o    (filtered_out_o),
  .window_median_o   (window_median_o)
);
